// ===== hdl/multichannel_sliding_median_filter_macros.svh =====
// Assertion macros used by the checker file of the median filter.
`ifndef MULTICHANNEL_SLIDING_MEDIAN_FILTER_MACROS_SVH
`define MULTICHANNEL_SLIDING_MEDIAN_FILTER_MACROS_SVH

// Property that is checked only while the block is out of reset.
`define MSMF_ASSERT_RUN(label, clk, rstn, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

// Property that is checked at every edge, reset included.
`define MSMF_ASSERT_ALWAYS(label, clk, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== hdl/msmf_pkg.sv =====
package msmf_pkg;

    localparam int SAMPLE_W  = 12;
    localparam int CHANNEL_W = 3;

    typedef struct packed {
        logic [CHANNEL_W-1:0] channel;
        logic [SAMPLE_W-1:0]  sample;
    } in_req_t;

    typedef struct packed {
        logic [CHANNEL_W-1:0] out_channel;
        logic [SAMPLE_W-1:0]  median;
    } out_res_t;

endpackage

// ===== hdl/msmf_median.sv =====
// Median of a small window by rank counting: every element compares itself
// against all others in parallel, ties broken by position, so the ranks form
// a permutation and the middle ranks pick the median.
module msmf_median #(
    parameter int WINDOW = 5
) (
    input  logic [WINDOW-1:0][msmf_pkg::SAMPLE_W-1:0] win,
    output logic [msmf_pkg::SAMPLE_W-1:0]             median
);

    localparam int SW     = msmf_pkg::SAMPLE_W;
    localparam int RANK_W = $clog2(WINDOW);
    localparam int MID    = WINDOW / 2;

    logic [RANK_W-1:0] rank [WINDOW];
    logic [SW-1:0]     lo;
    logic [SW-1:0]     hi;
    logic [SW:0]       sum;

    always_comb begin
        for (int i = 0; i < WINDOW; i++) begin
            rank[i] = '0;
            for (int j = 0; j < WINDOW; j++) begin
                if (j != i) begin
                    if ((win[j] < win[i]) || ((win[j] == win[i]) && (j < i))) begin
                        rank[i] = rank[i] + RANK_W'(1);
                    end
                end
            end
        end
    end

    always_comb begin
        lo = '0;
        hi = '0;
        for (int i = 0; i < WINDOW; i++) begin
            if (rank[i] == RANK_W'(MID)) begin
                hi = win[i];
            end
            if (rank[i] == RANK_W'(MID - 1)) begin
                lo = win[i];
            end
        end
    end

    assign sum    = {1'b0, lo} + {1'b0, hi};
    assign median = ((WINDOW % 2) != 0) ? hi : sum[SW:1];

endmodule

// ===== hdl/multichannel_sliding_median_filter.sv =====
// Sliding-window median filter for several proximity sensor channels.
// Input channel (s_valid, s_ready, s_data): one request carries a channel
// number and a raw sample. Result channel (m_valid, m_ready, m_data): one
// result per request, in request order, with the channel and the median of
// the last WINDOW-1 samples of that channel together with the new one.
// A channel number of CHANNELS or above leaves all history untouched and
// returns the sample itself as the median.
// A request passes stage 1, stage 2 and the output register before its
// result shows on m_valid. Throughput: one request per cycle unless the
// receiver stalls, set by the single read and single write per cycle of the
// history memory, one row per channel. A back-to-back request to the same
// channel gets the row just written through a forwarding register.
// Reset: aresetn is synchronous and active low. It empties the pipeline and
// clears one valid bit per history row, so every history reads as zeros
// again at once; no clearing pass is needed. s_ready is low during reset.
// When the receiver stalls, the result holds in the output register and the
// two internal stages fill up; s_ready drops only when all three are full.
module multichannel_sliding_median_filter #(
    parameter int WINDOW   = 5,
    parameter int CHANNELS = 6
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  msmf_pkg::in_req_t  s_data,
    output logic               m_valid,
    input  logic               m_ready,
    output msmf_pkg::out_res_t m_data
);

    localparam int SW     = msmf_pkg::SAMPLE_W;
    localparam int HIST   = WINDOW - 1;
    localparam int ROW_W  = HIST * SW;
    localparam int ADDR_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

    // History memory: one row per channel, oldest sample in the low slot.
    logic [ROW_W-1:0] hist_mem [CHANNELS];

    // Handshake between stages.
    logic s_acc;
    logic s1_load;
    logic s1_adv;
    logic s2_load;
    logic s2_adv;
    logic m_load;
    logic wr_en;

    logic              s_in_range;
    logic [ADDR_W-1:0] s_addr;

    // Stage 1: memory read data arrives.
    logic                s1_valid_reg;
    msmf_pkg::in_req_t   s1_req_reg;
    logic                s1_in_range_reg;
    logic [ADDR_W-1:0]   s1_addr_reg;
    logic [ROW_W-1:0]    rd_row_reg;
    logic                rd_valid_reg;
    logic                fwd_hit_reg;
    logic [ROW_W-1:0]    fwd_row_reg;
    logic [CHANNELS-1:0] row_valid_reg;

    logic [ROW_W-1:0]             row_cur;
    logic [ROW_W-1:0]             new_row;
    logic [WINDOW-1:0][SW-1:0]    s2_win_next;

    // Stage 2: assembled window.
    logic                         s2_valid_reg;
    logic [msmf_pkg::CHANNEL_W-1:0] s2_chan_reg;
    logic [WINDOW-1:0][SW-1:0]    s2_win_reg;

    logic [SW-1:0]      median_next;

    // Output register.
    logic               m_valid_reg;
    msmf_pkg::out_res_t m_data_reg;

    // Each stage loads when it is empty or its contents move on.
    assign m_load  = !m_valid_reg || m_ready;
    assign s2_adv  = s2_valid_reg && m_load;
    assign s2_load = !s2_valid_reg || m_load;
    assign s1_adv  = s1_valid_reg && s2_load;
    assign s1_load = !s1_valid_reg || s2_load;
    assign s_ready = aresetn && s1_load;
    assign s_acc   = s_valid && s_ready;

    assign s_in_range = (32'(s_data.channel) < CHANNELS);
    assign s_addr     = ADDR_W'(s_data.channel);

    // The row of the item in stage 1 is written back as it leaves.
    assign wr_en = s1_adv && s1_in_range_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            hist_mem[s1_addr_reg] <= new_row;
        end
        if (s_acc) begin
            rd_row_reg <= hist_mem[s_addr];
        end
    end

    // Rows never written since reset read as zeros.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            row_valid_reg <= '0;
        end else if (wr_en) begin
            row_valid_reg[s1_addr_reg] <= 1'b1;
        end
    end

    // The memory read sees the old row when the same channel is written at
    // the same edge, so that write is captured for forwarding.
    always_ff @(posedge aclk) begin
        if (s_acc) begin
            s1_req_reg      <= s_data;
            s1_in_range_reg <= s_in_range;
            s1_addr_reg     <= s_addr;
            rd_valid_reg    <= s_in_range && row_valid_reg[s_addr];
            fwd_hit_reg     <= wr_en && (s1_addr_reg == s_addr);
            fwd_row_reg     <= new_row;
        end
    end

    assign row_cur = fwd_hit_reg ? fwd_row_reg : (rd_valid_reg ? rd_row_reg : '0);

    // Shift the new sample into the row; build the window. An out-of-range
    // channel fills the whole window with the sample, whose median is itself.
    for (genvar k = 0; k < HIST; k++) begin : g_shift
        if (k == HIST - 1) begin : g_top
            assign new_row[k*SW +: SW] = s1_req_reg.sample;
        end else begin : g_mid
            assign new_row[k*SW +: SW] = row_cur[(k+1)*SW +: SW];
        end
        assign s2_win_next[k] = s1_in_range_reg ? row_cur[k*SW +: SW] : s1_req_reg.sample;
    end
    assign s2_win_next[WINDOW-1] = s1_req_reg.sample;

    always_ff @(posedge aclk) begin
        if (s1_adv) begin
            s2_chan_reg <= s1_req_reg.channel;
            s2_win_reg  <= s2_win_next;
        end
    end

    msmf_median #(
        .WINDOW (WINDOW)
    ) u_median (
        .win    (s2_win_reg),
        .median (median_next)
    );

    always_ff @(posedge aclk) begin
        if (s2_adv) begin
            m_data_reg.out_channel <= s2_chan_reg;
            m_data_reg.median      <= median_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            m_valid_reg  <= 1'b0;
        end else begin
            if (s1_load) begin
                s1_valid_reg <= s_acc;
            end
            if (s2_load) begin
                s2_valid_reg <= s1_valid_reg;
            end
            if (m_load) begin
                m_valid_reg <= s2_valid_reg;
            end
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

endmodule

// ===== hdl/msmf_checker.sv =====
`include "multichannel_sliding_median_filter_macros.svh"

module msmf_checker #(
    parameter int CHANNELS = 6
) (
    input logic               aclk,
    input logic               aresetn,
    input logic               s_valid,
    input logic               s_ready,
    input msmf_pkg::in_req_t  s_data,
    input logic               m_valid,
    input logic               m_ready,
    input msmf_pkg::out_res_t m_data
);

    `MSMF_ASSERT_ALWAYS(a_reset_clears, aclk, !aresetn |=> !m_valid, "result valid after reset")
    `MSMF_ASSERT_RUN(a_hold, aclk, aresetn, m_valid && !m_ready |=> m_valid && $stable(m_data), "stalled result changed")
    `MSMF_ASSERT_RUN(a_rise_channel, aclk, aresetn, $rose(m_valid) |-> $past(s_valid && s_ready, 3) && (m_data.out_channel == $past(s_data.channel, 3)), "result without matching request")
    `MSMF_ASSERT_RUN(a_bad_channel, aclk, aresetn, $rose(m_valid) && (32'(m_data.out_channel) >= CHANNELS) |-> m_data.median == $past(s_data.sample, 3), "out-of-range channel not passed through")

endmodule

bind multichannel_sliding_median_filter msmf_checker #(
    .CHANNELS (CHANNELS)
) u_msmf_checker (.*);
